### sv/rtr_pkg.sv
// Shared types and protocol constants for the radio telegram receiver.
package rtr_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned POS_W    = 4;

  // Register index taken from paddr[2] (one 32-bit word per register).
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic [7:0] TIMEOUT_RESET = 8'd20;

  // Byte codes on the serial line.
  localparam logic [7:0] BYTE_HANDSHAKE = 8'hFA;
  localparam logic [7:0] BYTE_REPLY     = 8'h05;
  localparam logic [7:0] BYTE_START     = 8'h55;
  localparam logic [7:0] BYTE_END       = 8'hAA;
  localparam logic [7:0] BYTE_STATUS_1  = 8'hCD;
  localparam logic [7:0] BYTE_STATUS_2  = 8'hF1;
  localparam logic [7:0] BYTE_STATUS_3  = 8'hFA;

  // Board option codes in byte 4 of a status frame.
  localparam logic [7:0] OPT_CODE_RX_TX   = 8'hAA;
  localparam logic [7:0] OPT_CODE_RX_ONLY = 8'hF0;
  localparam logic [7:0] OPT_CODE_TX_ONLY = 8'h0F;

  // Channel key ranges of byte 3.
  localparam logic [7:0] CHAN_A_HI = 8'h17;
  localparam logic [7:0] CHAN_B_LO = 8'h20;
  localparam logic [7:0] CHAN_B_HI = 8'h57;
  localparam logic [7:0] CHAN_C_LO = 8'h60;
  localparam logic [7:0] CHAN_C_HI = 8'h97;
  localparam logic [2:0] SCENE_MAX_CODE = 3'd4;
  localparam logic [3:0] LOCAL_SCENE_NIB = 4'hD;
  localparam logic [1:0] TOP_PLUS = 2'b01;
  localparam logic [1:0] TOP_STOP = 2'b00;
  localparam logic [1:0] DB3_SHORT_LAST = 2'b01;

  // Frame byte positions.
  localparam logic [POS_W-1:0] POS_FIRST_DATA = 4'd1;
  localparam logic [POS_W-1:0] POS_SW1 = 4'd1;
  localparam logic [POS_W-1:0] POS_SW2 = 4'd2;
  localparam logic [POS_W-1:0] POS_DB1 = 4'd3;
  localparam logic [POS_W-1:0] POS_DB2 = 4'd4;
  localparam logic [POS_W-1:0] POS_DB3 = 4'd5;
  localparam logic [POS_W-1:0] POS_CRC = 4'd10;
  localparam logic [POS_W-1:0] POS_LAST = 4'd11;

  typedef enum logic [1:0] {
    KIND_HANDSHAKE = 2'd0,
    KIND_KEY       = 2'd1,
    KIND_BOARD     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OPT_RX_TX   = 2'd0,
    OPT_RX_ONLY = 2'd1,
    OPT_TX_ONLY = 2'd2,
    OPT_UNKNOWN = 2'd3
  } board_opt_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  tx_byte;
    logic        frame_ok;
    logic [2:0]  key_group;
    logic [3:0]  key_channel;
    logic        plus_side;
    logic        switch_on;
    logic [2:0]  light_scene;
    logic        master_key;
    logic        all_on_off;
    board_opt_t  board_option;
  } result_t;

endpackage

### sv/radio_telegram_receiver_unit.sv
// Radio telegram receiver: frame collection, checksum and key decoding.
// Each beat on the input carries a received byte or one time tick; a new
// beat is accepted every cycle unless input is held off. Results go
// into a two-entry output register (main stage plus skid stage), so input
// is only held off when both entries are full. A result is registered into
// the main stage, or into the skid stage when the main stage is full and
// is not being read. The only stored frame bytes are those the decoder
// needs; the checksum runs as bytes arrive.
module radio_telegram_receiver_unit
  import rtr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        result_kind,
  output logic [7:0]        tx_byte,
  output logic              frame_ok,
  output logic [2:0]        key_group,
  output logic [3:0]        key_channel,
  output logic              plus_side,
  output logic              switch_on,
  output logic [2:0]        light_scene,
  output logic              master_key,
  output logic              all_on_off,
  output logic [1:0]        board_option,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [7:0]       timeout;
  logic             collecting, collecting_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       wait_ticks, wait_ticks_next;
  logic [7:0]       sw1, sw2, db1, db2, db3, crc_byte;

  logic             in_fire, pop, emit;
  result_t          res, dec, out_res, skid_res;
  logic             skid_valid;

  assign pready   = 1'b1;
  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
      timeout <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_TIMEOUT) ? {{(DATA_W-8){1'b0}}, timeout} : '0;

  // Frame decoder, fed by the stored bytes and the end byte on the input.
  always_comb begin
    logic status_frame;
    logic chan_key;
    logic plus_mod;
    status_frame = (sw1 == BYTE_STATUS_1) && (sw2 == BYTE_STATUS_2)
                   && (db1 == BYTE_STATUS_3);
    chan_key = (db1 <= CHAN_A_HI) || (db1 >= CHAN_B_LO && db1 <= CHAN_B_HI)
               || (db1 >= CHAN_C_LO && db1 <= CHAN_C_HI);
    plus_mod = (db1[7:6] == TOP_PLUS);
    dec = '0;
    dec.frame_ok = (crc_byte == (8'd0 - running_sum)) && (rx_byte == BYTE_END);
    if (status_frame) begin
      dec.result_kind = KIND_BOARD;
      priority if (db2 == OPT_CODE_RX_TX) begin
        dec.board_option = OPT_RX_TX;
      end else if (db2 == OPT_CODE_RX_ONLY) begin
        dec.board_option = OPT_RX_ONLY;
      end else if (db2 == OPT_CODE_TX_ONLY) begin
        dec.board_option = OPT_TX_ONLY;
      end else begin
        dec.board_option = OPT_UNKNOWN;
      end
    end else begin
      dec.result_kind = KIND_KEY;
      dec.plus_side   = 1'b1;
      priority if (chan_key) begin
        dec.key_channel = {1'b0, db1[2:0]} + 4'd1;
        dec.key_group   = {1'b0, db1[4:3]} + 3'd1;
        dec.plus_side   = plus_mod;
      end else if (db1[2:0] <= SCENE_MAX_CODE) begin
        dec.light_scene = db1[2:0] + 3'd1;
        if (db1[7:4] != LOCAL_SCENE_NIB) begin
          dec.master_key = 1'b1;
          dec.plus_side  = plus_mod;
        end
      end else begin
        dec.all_on_off = 1'b1;
        dec.plus_side  = db1[0];
      end
      dec.switch_on = !((db1[7:6] == TOP_STOP) || (db3[7:6] == DB3_SHORT_LAST));
    end
  end

  // Next state of the receiver and the result of this beat.
  always_comb begin
    collecting_next    = collecting;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    wait_ticks_next    = wait_ticks;
    emit = 1'b0;
    res  = '0;
    if (in_fire) begin
      if (action) begin
        if (collecting) begin
          if (wait_ticks >= timeout) begin
            collecting_next    = 1'b0;
            byte_position_next = '0;
            running_sum_next   = '0;
            wait_ticks_next    = '0;
          end else begin
            wait_ticks_next = wait_ticks + 8'd1;
          end
        end
      end else if (!collecting) begin
        if (rx_byte == BYTE_HANDSHAKE) begin
          emit = 1'b1;
          res.result_kind = KIND_HANDSHAKE;
          res.tx_byte     = BYTE_REPLY;
        end else if (rx_byte == BYTE_START) begin
          collecting_next    = 1'b1;
          byte_position_next = POS_FIRST_DATA;
          running_sum_next   = rx_byte;
          wait_ticks_next    = '0;
        end
      end else if (byte_position == POS_LAST) begin
        emit = 1'b1;
        res  = dec;
        collecting_next    = 1'b0;
        byte_position_next = '0;
        running_sum_next   = '0;
        wait_ticks_next    = '0;
      end else begin
        byte_position_next = byte_position + 4'd1;
        if (byte_position < POS_CRC) begin
          running_sum_next = running_sum + rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      byte_position <= '0;
      running_sum   <= '0;
      wait_ticks    <= '0;
    end else begin
      collecting    <= collecting_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      wait_ticks    <= wait_ticks_next;
    end
  end

  // Only the frame bytes the decoder reads are kept.
  always_ff @(posedge clk) begin
    if (in_fire && !action && collecting) begin
      unique case (byte_position)
        POS_SW1: sw1      <= rx_byte;
        POS_SW2: sw2      <= rx_byte;
        POS_DB1: db1      <= rx_byte;
        POS_DB2: db2      <= rx_byte;
        POS_DB3: db3      <= rx_byte;
        POS_CRC: crc_byte <= rx_byte;
        default: ;
      endcase
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (emit && out_valid && !pop) begin
      skid_valid <= 1'b1;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (emit && out_valid && !pop) begin
      skid_res <= res;
    end else if (emit) begin
      out_res <= res;
    end
  end

  assign result_kind  = out_res.result_kind;
  assign tx_byte      = out_res.tx_byte;
  assign frame_ok     = out_res.frame_ok;
  assign key_group    = out_res.key_group;
  assign key_channel  = out_res.key_channel;
  assign plus_side    = out_res.plus_side;
  assign switch_on    = out_res.switch_on;
  assign light_scene  = out_res.light_scene;
  assign master_key   = out_res.master_key;
  assign all_on_off   = out_res.all_on_off;
  assign board_option = out_res.board_option;

endmodule

### sv/rtr_checker.sv
// Port-level checker for the radio telegram receiver, bound to the top level.
module rtr_checker
  import rtr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              action,
  input logic [7:0]        rx_byte,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        result_kind,
  input logic [7:0]        tx_byte,
  input logic              frame_ok,
  input logic [2:0]        key_group,
  input logic [3:0]        key_channel,
  input logic              plus_side,
  input logic              switch_on,
  input logic [2:0]        light_scene,
  input logic              master_key,
  input logic              all_on_off,
  input logic [1:0]        board_option,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  // A stalled result beat keeps its kind, transmit byte, frame flag and key channel.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind)
      && $stable(tx_byte) && $stable(frame_ok) && $stable(key_channel))
    else $error("result beat changed while stalled");

  // A handshake reply carries only the reply byte.
  a_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_HANDSHAKE |-> tx_byte == BYTE_REPLY
      && !frame_ok && key_channel == 4'd0 && light_scene == 3'd0
      && board_option == 2'd0)
    else $error("malformed handshake reply");

  // Frame results never carry a transmit byte.
  a_frame_tx: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_KEY || result_kind == KIND_BOARD)
      |-> tx_byte == 8'd0)
    else $error("frame result with transmit byte");

  // Channel and group come together, and never with a scene or all command.
  a_key_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_KEY |-> board_option == 2'd0
      && ((key_channel == 4'd0) == (key_group == 3'd0))
      && $countones({key_channel != 4'd0, light_scene != 3'd0, all_on_off}) == 1)
    else $error("inconsistent key telegram fields");

  // With the output empty, a result beat can only appear after an accepted
  // input beat.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) && !out_valid |=> !out_valid)
    else $error("result without an accepted input beat");

endmodule

bind radio_telegram_receiver_unit rtr_checker u_rtr_checker (.*);

### dv/radio_telegram_receiver_unit_test.sv
// Self-checking testbench for the radio telegram receiver unit.
`timescale 1ns / 1ps

module radio_telegram_receiver_unit_test;
  import rtr_pkg::*;

  localparam int FRAME_BYTES = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [ADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic action;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_ready;
  logic [1:0] result_kind;
  logic [7:0] tx_byte;
  logic frame_ok;
  logic [2:0] key_group;
  logic [3:0] key_channel;
  logic plus_side;
  logic switch_on;
  logic [2:0] light_scene;
  logic master_key;
  logic all_on_off;
  logic [1:0] board_option;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Mirror of the receiver state, advanced once per accepted input beat.
  logic rcv_busy;
  logic [3:0] frame_pos;
  logic [7:0] frame_buf [FRAME_BYTES];
  logic [7:0] frame_sum;
  logic [7:0] tick_count;
  logic [7:0] timeout_reg;

  result_t telegram_queue [$];
  logic [7:0] pending_frame [FRAME_BYTES];
  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_cycles = 0;

  radio_telegram_receiver_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .tx_byte(tx_byte),
    .frame_ok(frame_ok),
    .key_group(key_group),
    .key_channel(key_channel),
    .plus_side(plus_side),
    .switch_on(switch_on),
    .light_scene(light_scene),
    .master_key(master_key),
    .all_on_off(all_on_off),
    .board_option(board_option),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver side stalls at random, or holds off entirely while a
  // hold-off count is pending.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void clear_frame_state();
    rcv_busy = 1'b0;
    frame_pos = '0;
    frame_sum = '0;
    tick_count = '0;
  endfunction

  function automatic void decode_telegram(output result_t r);
    logic [7:0] db1;
    logic [7:0] db3;
    logic [7:0] crc;
    r = '0;
    db1 = frame_buf[POS_DB1];
    db3 = frame_buf[POS_DB3];
    crc = 8'h00 - frame_sum;
    r.frame_ok = (crc == frame_buf[POS_CRC]) && (frame_buf[POS_LAST] == BYTE_END);
    if (frame_buf[POS_SW1] == BYTE_STATUS_1 && frame_buf[POS_SW2] == BYTE_STATUS_2
        && db1 == BYTE_STATUS_3) begin
      r.result_kind = KIND_BOARD;
      case (frame_buf[POS_DB2])
        OPT_CODE_RX_TX: r.board_option = OPT_RX_TX;
        OPT_CODE_RX_ONLY: r.board_option = OPT_RX_ONLY;
        OPT_CODE_TX_ONLY: r.board_option = OPT_TX_ONLY;
        default: r.board_option = OPT_UNKNOWN;
      endcase
      return;
    end
    r.result_kind = KIND_KEY;
    r.plus_side = 1'b1;
    r.switch_on = 1'b1;
    if (db1 <= CHAN_A_HI || (db1 >= CHAN_B_LO && db1 <= CHAN_B_HI)
        || (db1 >= CHAN_C_LO && db1 <= CHAN_C_HI)) begin
      r.key_channel = {1'b0, db1[2:0]} + 4'd1;
      r.key_group = {1'b0, db1[4:3]} + 3'd1;
      r.plus_side = (db1[7:6] == TOP_PLUS);
    end else if (db1[2:0] <= SCENE_MAX_CODE) begin
      r.light_scene = db1[2:0] + 3'd1;
      if (db1[7:4] != LOCAL_SCENE_NIB) begin
        r.master_key = 1'b1;
        r.plus_side = (db1[7:6] == TOP_PLUS);
      end
    end else begin
      r.all_on_off = 1'b1;
      r.plus_side = db1[0];
    end
    if (db1[7:6] == TOP_STOP) r.switch_on = 1'b0;
    if (db1[7:6] != TOP_STOP && db3[7:6] == DB3_SHORT_LAST) r.switch_on = 1'b0;
  endfunction

  // Advances the mirrored state by one beat; returns 1 when a telegram
  // result is due.
  function automatic bit receive_beat(input logic act, input logic [7:0] b,
                                      output result_t r);
    r = '0;
    if (act) begin
      if (rcv_busy) begin
        if (tick_count >= timeout_reg) clear_frame_state();
        else tick_count++;
      end
      return 1'b0;
    end
    if (!rcv_busy) begin
      if (b == BYTE_HANDSHAKE) begin
        r.result_kind = KIND_HANDSHAKE;
        r.tx_byte = BYTE_REPLY;
        return 1'b1;
      end
      if (b == BYTE_START) begin
        rcv_busy = 1'b1;
        frame_buf[0] = b;
        frame_sum = b;
        frame_pos = POS_FIRST_DATA;
        tick_count = '0;
      end
      return 1'b0;
    end
    frame_buf[frame_pos] = b;
    if (frame_pos < POS_CRC) frame_sum = frame_sum + b;
    frame_pos++;
    if (frame_pos < FRAME_BYTES) return 1'b0;
    decode_telegram(r);
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (telegram_queue.size() == 0) begin
        $error("result beat with no telegram expected");
        err_count++;
      end else begin
        want = telegram_queue.pop_front();
        compare_field("result_kind", want.result_kind, result_kind);
        compare_field("tx_byte", want.tx_byte, tx_byte);
        compare_field("frame_ok", want.frame_ok, frame_ok);
        compare_field("key_group", want.key_group, key_group);
        compare_field("key_channel", want.key_channel, key_channel);
        compare_field("plus_side", want.plus_side, plus_side);
        compare_field("switch_on", want.switch_on, switch_on);
        compare_field("light_scene", want.light_scene, light_scene);
        compare_field("master_key", want.master_key, master_key);
        compare_field("all_on_off", want.all_on_off, all_on_off);
        compare_field("board_option", want.board_option, board_option);
      end
    end
  end

  // Offers one beat, after a random gap, and holds it until accepted.
  task automatic send_beat(input logic act, input logic [7:0] b);
    result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (receive_beat(act, b, r)) telegram_queue.push_back(r);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_beat(1'b1, 8'h00);
  endtask

  // Stops offering input and waits until every telegram has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (telegram_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_timeout(input logic [7:0] value);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_ADDR;
    pwdata <= {{(DATA_W-8){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    timeout_reg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(DATA_W-8){1'b0}}, value}) begin
      $error("timeout readback: expected %0h, got %0h", value, prdata);
      err_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic seal_frame();
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < POS_CRC; i++) sum = sum + pending_frame[i];
    pending_frame[POS_CRC] = 8'h00 - sum;
    pending_frame[POS_LAST] = BYTE_END;
  endtask

  // Sends the pending frame, now and then slipping ticks between bytes.
  task automatic send_pending_frame(input int tick_pct);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if ($urandom_range(99) < tick_pct) send_ticks($urandom_range(1, 2));
      send_beat(1'b0, pending_frame[i]);
    end
  endtask

  function automatic logic [7:0] pick_key_code();
    case ($urandom_range(15))
      0: return 8'h00;
      1: return CHAN_A_HI;
      2: return 8'h18;
      3: return CHAN_B_LO;
      4: return CHAN_B_HI;
      5: return 8'h58;
      6: return CHAN_C_LO;
      7: return CHAN_C_HI;
      8: return 8'h98;
      9: return 8'hC0;
      10: return 8'hC4;
      11: return 8'hD0;
      12: return 8'hD4;
      13: return 8'hC5;
      14: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic build_random_frame();
    pending_frame[0] = BYTE_START;
    for (int i = 1; i < FRAME_BYTES; i++) pending_frame[i] = 8'($urandom_range(255));
    if ($urandom_range(99) < 20) begin
      pending_frame[POS_SW1] = BYTE_STATUS_1;
      pending_frame[POS_SW2] = BYTE_STATUS_2;
      pending_frame[POS_DB1] = BYTE_STATUS_3;
      case ($urandom_range(3))
        0: pending_frame[POS_DB2] = OPT_CODE_RX_TX;
        1: pending_frame[POS_DB2] = OPT_CODE_RX_ONLY;
        2: pending_frame[POS_DB2] = OPT_CODE_TX_ONLY;
        default: ;
      endcase
    end else if ($urandom_range(1)) begin
      pending_frame[POS_DB1] = pick_key_code();
    end
    if ($urandom_range(1)) pending_frame[POS_DB3][7:6] = DB3_SHORT_LAST;
    seal_frame();
    if ($urandom_range(99) < 15) pending_frame[POS_CRC] = 8'($urandom_range(255));
    if ($urandom_range(99) < 15) pending_frame[POS_LAST] = 8'($urandom_range(255));
  endtask

  task automatic test_idle_bytes();
    send_beat(1'b0, BYTE_HANDSHAKE);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, BYTE_END);
    send_ticks(1);
    send_beat(1'b0, BYTE_HANDSHAKE);
    drain_results();
  endtask

  task automatic test_frame_decoding();
    // Handshake and start codes inside a frame are plain data.
    pending_frame = '{8'h55, 8'hFA, 8'h55, 8'h21, 8'h00, 8'h45,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    seal_frame();
    send_pending_frame(0);
    // Status query with a broken end byte.
    pending_frame = '{8'h55, 8'hCD, 8'hF1, 8'hFA, 8'hF0, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    seal_frame();
    pending_frame[POS_LAST] = 8'h00;
    send_pending_frame(0);
    // All on/off key with a checksum that is off by one bit.
    pending_frame = '{8'h55, 8'h01, 8'h02, 8'hC5, 8'hFF, 8'h80,
                      8'h7F, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00};
    seal_frame();
    pending_frame[POS_CRC] = pending_frame[POS_CRC] ^ 8'h01;
    send_pending_frame(0);
    drain_results();
  endtask

  task automatic test_partial_frame_timeout();
    // A zero wait drops the frame on its first tick.
    program_timeout(8'd0);
    send_beat(1'b0, BYTE_START);
    send_ticks(1);
    send_beat(1'b0, BYTE_HANDSHAKE);
    program_timeout(8'd1);
    send_beat(1'b0, BYTE_START);
    send_ticks(1);
    send_beat(1'b0, 8'h10);
    send_ticks(1);
    send_beat(1'b0, BYTE_HANDSHAKE);
    // At the longest wait, 255 ticks are survived and the 256th drops.
    program_timeout(8'd255);
    build_random_frame();
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i == 6) send_ticks(255);
      send_beat(1'b0, pending_frame[i]);
    end
    build_random_frame();
    for (int i = 0; i < 4; i++) send_beat(1'b0, pending_frame[i]);
    send_ticks(256);
    send_beat(1'b0, BYTE_HANDSHAKE);
    drain_results();
  endtask

  // The receiver holds off long enough for the output stage to fill up
  // while handshake requests keep coming.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 300;
    repeat (30) send_beat(1'b0, BYTE_HANDSHAKE);
    drain_results();
  endtask

  task automatic run_random_phase(input int item_goal, input int send_pct,
                                  input int recv_pct, input logic [7:0] wait_limit);
    int counted;
    int sel;
    program_timeout(wait_limit);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    counted = 0;
    while (counted < item_goal) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        build_random_frame();
        send_pending_frame(5);
        counted += FRAME_BYTES;
      end else if (sel < 80) begin
        send_beat(1'b0, BYTE_HANDSHAKE);
        counted++;
      end else if (sel < 92) begin
        send_beat(1'b0, 8'($urandom_range(255)));
        counted++;
      end else if (sel < 97) begin
        send_ticks(1);
        counted++;
      end else begin
        drain_results();
      end
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    run_random_phase(60, 0, 0, TIMEOUT_RESET);
    run_random_phase(60, 64, 0, 8'd255);
    run_random_phase(60, 0, 64, 8'd1);
    run_random_phase(60, 9, 9, 8'($urandom_range(1, 255)));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = 1'b0;
    rx_byte = 8'h00;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    timeout_reg = TIMEOUT_RESET;
    clear_frame_state();
    for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_idle_bytes();
    test_frame_decoding();
    test_partial_frame_timeout();
    test_output_backpressure();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### radio_telegram_receiver_unit.f
sv/rtr_pkg.sv
sv/radio_telegram_receiver_unit.sv
sv/rtr_checker.sv
dv/radio_telegram_receiver_unit_test.sv
